/* src/stq_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Shared types, codes and defaults for the sorted delay timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

    // Default number of pending wake-ups the queue can hold.
    localparam int CAPACITY_DEF = 8;

    localparam int TIME_W  = 64;
    localparam int TAG_W   = 8;
    localparam int DELAY_W = 32;
    localparam int RATE_W  = 20;
    localparam int STAT_W  = 3;
    // A non-negative delay has DELAY_W-1 magnitude bits.
    localparam int MAG_W   = DELAY_W - 1;
    localparam int PROD_W  = MAG_W + RATE_W;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_TICKS_PER_MS = '0;
    localparam logic [RATE_W-1:0]  TICKS_PER_MS_RST = RATE_W'(1000);

    // Opcodes.
    localparam logic OP_DELAY = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_ACCEPTED    = 3'd0;
    localparam logic [STAT_W-1:0] ST_WOKEN       = 3'd1;
    localparam logic [STAT_W-1:0] ST_QUEUE_FULL  = 3'd2;
    localparam logic [STAT_W-1:0] ST_NEG_DELAY   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTHING_DUE = 3'd4;

    typedef struct packed {
        logic                      opcode;
        logic [TAG_W-1:0]          process_tag;
        logic signed [DELAY_W-1:0] delay_ms;
        logic [TIME_W-1:0]         now;
    } in_word_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TAG_W-1:0]  woken_tag;
        logic              last;
    } out_word_t;

    // One queue slot.
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] wake;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic              insert;
        logic              pop;
        logic [TIME_W-1:0] wake;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] now;
    } chain_ctl_t;

    // Status returned by the chain to the controller.
    typedef struct packed {
        logic             head_due;
        logic             next_due;
        logic             full;
        logic [TAG_W-1:0] head_tag;
    } chain_stat_t;

endpackage

/* src/stq_cell.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue cell
// Holds one wake-up entry and shifts towards either neighbour on insert or pop.
// ----------------------------------------------------------------------------
module stq_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  stq_pkg::chain_ctl_t ctl,
    input  stq_pkg::entry_t     left_entry,
    input  logic                left_ge,
    input  stq_pkg::entry_t     right_entry,
    output stq_pkg::entry_t     entry,
    output logic                ge,
    output logic                due
);
    import stq_pkg::*;

    logic              valid_reg, valid_next;
    logic [TIME_W-1:0] wake_reg, wake_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;

    // The new entry belongs at or before this cell; equal times go in front.
    assign ge  = !valid_reg || (ctl.wake <= wake_reg);
    assign due = valid_reg && (wake_reg <= ctl.now);

    assign entry = '{valid: valid_reg, wake: wake_reg, tag: tag_reg};

    always_comb begin
        valid_next = valid_reg;
        wake_next  = wake_reg;
        tag_next   = tag_reg;
        if (ctl.insert) begin
            if (ge) begin
                if (left_ge) begin
                    valid_next = left_entry.valid;
                    wake_next  = left_entry.wake;
                    tag_next   = left_entry.tag;
                end else begin
                    valid_next = 1'b1;
                    wake_next  = ctl.wake;
                    tag_next   = ctl.tag;
                end
            end
        end else if (ctl.pop) begin
            valid_next = right_entry.valid;
            wake_next  = right_entry.wake;
            tag_next   = right_entry.tag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wake_reg <= wake_next;
        tag_reg  <= tag_next;
    end

endmodule

/* src/stq_chain.sv */
// ----------------------------------------------------------------------------
// Sorted timer queue chain
// A row of cells kept in ascending wake order, head at cell zero.
// ----------------------------------------------------------------------------
module stq_chain #(
    parameter int CAPACITY = stq_pkg::CAPACITY_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  stq_pkg::chain_ctl_t  ctl,
    output stq_pkg::chain_stat_t stat
);
    import stq_pkg::*;

    entry_t cells [CAPACITY];
    logic   ge    [CAPACITY];
    logic   due   [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   left_g;

        if (i == 0) begin : g_first
            assign left_e = '0;
            assign left_g = 1'b0;
        end else begin : g_mid
            assign left_e = cells[i-1];
            assign left_g = ge[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_e = '0;
        end else begin : g_inner
            assign right_e = cells[i+1];
        end

        stq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .left_entry  (left_e),
            .left_ge     (left_g),
            .right_entry (right_e),
            .entry       (cells[i]),
            .ge          (ge[i]),
            .due         (due[i])
        );
    end

    if (CAPACITY > 1) begin : g_next
        assign stat.next_due = due[1];
    end else begin : g_no_next
        assign stat.next_due = 1'b0;
    end

    assign stat.head_due = due[0];
    assign stat.head_tag = cells[0].tag;
    // Entries are contiguous from the head, so the tail cell tells fullness.
    assign stat.full     = cells[CAPACITY-1].valid;

endmodule

/* src/sorted_delay_timer_queue_core.sv */
// ----------------------------------------------------------------------------
// Sorted delay timer queue core
// Holds pending wake-ups sorted by wake time and releases them on ticks.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                      | Carries
//  --------+----------------------------+---------------------------------------
//  input   | s_valid, s_ready, s_data   | delay request or tick word
//  result  | m_valid, m_ready, m_data   | status, woken tag and last flag
//  config  | psel, penable, pwrite, ... | ticks_per_ms at byte address 0
//
// A delay request passes from acceptance to its result word through the request
// register, the delay by rate multiplier, the 64-bit wake time adder and an
// insert into the cell chain in a single step.
// A tick is registered and then releases its due entries, since the chain pops
// one entry from its head in each cycle that the result channel is not stalled;
// a tick with nothing due gives one word. Reset is synchronous and clears the
// control state and every cell's valid bit at once, so no clearing pass is
// needed. A stalled result channel holds the output word and the sequencer in
// its insert, response or tick state.
module sorted_delay_timer_queue_core #(
    parameter int CAPACITY = stq_pkg::CAPACITY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  stq_pkg::in_word_t             s_data,

    output logic                          m_valid,
    input  logic                          m_ready,
    output stq_pkg::out_word_t            m_data,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stq_pkg::PADDR_W-1:0]   paddr,
    input  logic [stq_pkg::PDATA_W-1:0]   pwdata,
    output logic [stq_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import stq_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;
    localparam logic [2:0] S_TICK = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [RATE_W-1:0] tpm_reg;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [MAG_W-1:0]  dly_reg, dly_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [TIME_W-1:0] wake_reg, wake_next;
    logic [STAT_W-1:0] resp_reg, resp_next;

    logic              m_valid_reg, m_valid_next;
    out_word_t         m_data_reg, m_data_next;

    chain_ctl_t        chain_ctl;
    chain_stat_t       chain_stat;

    logic              s_fire;
    logic              slot_free;
    logic              cfg_write;

    // ------------------------------------------------------------------------
    // Configuration port. The register index sits above the byte offset.
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[PADDR_W-1:2] == REG_TICKS_PER_MS);
    assign prdata    = (paddr[PADDR_W-1:2] == REG_TICKS_PER_MS)
                       ? PDATA_W'(tpm_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpm_reg <= TICKS_PER_MS_RST;
        end else if (cfg_write) begin
            tpm_reg <= pwdata[RATE_W-1:0];
        end
    end

    // ------------------------------------------------------------------------
    // Handshake. The output register frees its slot when the word is taken.
    // ------------------------------------------------------------------------
    assign s_ready   = (state_reg == S_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // ------------------------------------------------------------------------
    // Sequencer and result generation.
    // ------------------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        tag_next     = tag_reg;
        dly_next     = dly_reg;
        now_next     = now_reg;
        prod_next    = prod_reg;
        wake_next    = wake_reg;
        resp_next    = resp_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        chain_ctl.insert = 1'b0;
        chain_ctl.pop    = 1'b0;
        chain_ctl.wake   = wake_reg;
        chain_ctl.tag    = tag_reg;
        chain_ctl.now    = now_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    tag_next = s_data.process_tag;
                    dly_next = s_data.delay_ms[MAG_W-1:0];
                    now_next = s_data.now;
                    // A negative delay is rejected before the full check.
                    priority if (s_data.opcode == OP_TICK) begin
                        state_next = S_TICK;
                    end else if (s_data.delay_ms[DELAY_W-1]) begin
                        resp_next  = ST_NEG_DELAY;
                        state_next = S_RESP;
                    end else if (chain_stat.full) begin
                        resp_next  = ST_QUEUE_FULL;
                        state_next = S_RESP;
                    end else begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL: begin
                prod_next  = PROD_W'(dly_reg) * PROD_W'(tpm_reg);
                state_next = S_ADD;
            end
            S_ADD: begin
                // The sum wraps modulo two to the sixty-fourth.
                wake_next  = now_reg + TIME_W'(prod_reg);
                state_next = S_INS;
            end
            S_INS: begin
                if (slot_free) begin
                    chain_ctl.insert = 1'b1;
                    m_valid_next     = 1'b1;
                    m_data_next      = '{status: ST_ACCEPTED, woken_tag: tag_reg,
                                         last: 1'b1};
                    state_next       = S_IDLE;
                end
            end
            S_RESP: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status: resp_reg, woken_tag: tag_reg, last: 1'b1};
                    state_next   = S_IDLE;
                end
            end
            S_TICK: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    if (chain_stat.head_due) begin
                        chain_ctl.pop = 1'b1;
                        m_data_next   = '{status: ST_WOKEN,
                                          woken_tag: chain_stat.head_tag,
                                          last: !chain_stat.next_due};
                        if (!chain_stat.next_due) begin
                            state_next = S_IDLE;
                        end
                    end else begin
                        // Only reachable on the first cycle of a tick.
                        m_data_next = '{status: ST_NOTHING_DUE, woken_tag: '0,
                                        last: 1'b1};
                        state_next  = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg    <= tag_next;
        dly_reg    <= dly_next;
        now_reg    <= now_next;
        prod_reg   <= prod_next;
        wake_reg   <= wake_next;
        resp_reg   <= resp_next;
        m_data_reg <= m_data_next;
    end

    // ------------------------------------------------------------------------
    // The sorted chain of entry cells.
    // ------------------------------------------------------------------------
    stq_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (chain_ctl),
        .stat    (chain_stat)
    );

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------

    // An entry is never inserted into a full chain.
    a_no_insert_full: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_ctl.insert |-> !chain_stat.full)
        else $error("insert into full timer queue");

    // A new word is only taken once the previous one has shown its last result.
    a_accept_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |-> !(m_valid && !m_data.last))
        else $error("input accepted while a result sequence is unfinished");

    // A pop that is not the last leaves a due entry at the head.
    a_pop_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (chain_ctl.pop && chain_stat.next_due) |=> chain_stat.head_due)
        else $error("next entry not due after a non-final pop");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted delay timer queue testbench
// Drives delay requests and ticks into the timer queue core, changes the
// tick rate over the configuration port between phases, and checks every
// result word against its table row or a bench predictor of the sorted queue.
// ----------------------------------------------------------------------------
module tb;
    import stq_pkg::*;

    localparam int CAPACITY    = CAPACITY_DEF;
    // Cycles without any accepted word before the run is declared hung. The
    // slowest legal gap is a sender pause, a delay request and a full
    // receiver stall, so this is far beyond anything a working block needs.
    localparam int IDLE_LIMIT  = 2000;
    // Cycles left after the last result word before the block counts as idle.
    localparam int SETTLE_CYC  = 12;
    localparam int PHASE_WORDS = 40;
    localparam int N_PHASES    = 6;

    // One line of the directed table: the word to send and, where it is
    // obvious, the single result word it must produce.
    typedef struct packed {
        in_word_t  stim;
        logic      typed;
        out_word_t want;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_word_t             s_data;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    out_word_t            m_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Bench copy of the queue: wake times and owners, earliest first.
    logic [TIME_W-1:0]    sched_wake[$];
    logic [TAG_W-1:0]     sched_tag[$];
    logic [RATE_W-1:0]    rate_ticks;
    // Words produced by the latest call of the predictor.
    out_word_t            step_words[$];
    // Result words still owed by the block, oldest first.
    out_word_t            awaited_words[$];
    dir_row_t             dir_rows[$];

    logic [TIME_W-1:0]    clock_now;
    bit                   tx_burst;
    bit                   rx_burst;
    int                   rx_hold;
    int unsigned          idle_cycles   = 0;
    int unsigned          error_count   = 0;
    int unsigned          words_sent;
    int unsigned          words_checked = 0;
    int unsigned          woken_seen    = 0;
    int unsigned          full_seen     = 0;
    int unsigned          neg_seen      = 0;
    int unsigned          none_due_seen = 0;

    sorted_delay_timer_queue_core #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor. Works out the result words of one accepted word and updates
    // the bench copy of the queue. A request is rejected for a negative delay
    // before the fullness check; otherwise its wake time, which wraps at 64
    // bits, is placed ahead of any entry with the same time. A tick releases
    // every entry due at or before its time, earliest first, and marks the
    // final release; with nothing due it gives a single nothing-due word.
    // ------------------------------------------------------------------------
    function automatic void advance_wakeups(in_word_t w);
        logic [TIME_W-1:0] wake;
        int unsigned       pos;
        int unsigned       due;
        step_words.delete();
        if (w.opcode == OP_DELAY) begin
            if (w.delay_ms[DELAY_W-1]) begin
                step_words.push_back('{ST_NEG_DELAY, w.process_tag, 1'b1});
            end else if (sched_wake.size() >= CAPACITY) begin
                step_words.push_back('{ST_QUEUE_FULL, w.process_tag, 1'b1});
            end else begin
                wake = w.now + {32'b0, w.delay_ms} * {44'b0, rate_ticks};
                pos = 0;
                while (pos < sched_wake.size() && wake > sched_wake[pos])
                    pos++;
                sched_wake.insert(pos, wake);
                sched_tag.insert(pos, w.process_tag);
                step_words.push_back('{ST_ACCEPTED, w.process_tag, 1'b1});
            end
        end else begin
            due = 0;
            while (due < sched_wake.size() && sched_wake[due] <= w.now)
                due++;
            if (due == 0)
                step_words.push_back('{ST_NOTHING_DUE, '0, 1'b1});
            for (int j = 0; j < due; j++) begin
                step_words.push_back('{ST_WOKEN, sched_tag[0], j == due - 1});
                void'(sched_wake.pop_front());
                void'(sched_tag.pop_front());
            end
        end
    endfunction

    function automatic dir_row_t mk_row(logic op, logic [TAG_W-1:0] tag,
                                        logic [DELAY_W-1:0] dly,
                                        logic [TIME_W-1:0] now, logic typed,
                                        logic [STAT_W-1:0] st,
                                        logic [TAG_W-1:0] wtag);
        dir_row_t r;
        r.stim  = '{op, tag, dly, now};
        r.typed = typed;
        r.want  = '{st, wtag, 1'b1};
        return r;
    endfunction

    // Compares one result word with the oldest one still owed.
    function automatic void check_result_word(out_word_t got);
        out_word_t want;
        words_checked++;
        case (got.status)
            ST_WOKEN:       woken_seen++;
            ST_QUEUE_FULL:  full_seen++;
            ST_NEG_DELAY:   neg_seen++;
            ST_NOTHING_DUE: none_due_seen++;
            default: ;
        endcase
        if (awaited_words.size() == 0) begin
            $display("%0t: result word with none owed: status %0d tag %02h last %0d",
                     $time, got.status, got.woken_tag, got.last);
            error_count++;
            return;
        end
        want = awaited_words.pop_front();
        if (got.status != want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
            error_count++;
        end
        if (got.woken_tag != want.woken_tag) begin
            $display("%0t: tag mismatch: expected %02h, actual %02h",
                     $time, want.woken_tag, got.woken_tag);
            error_count++;
        end
        if (got.last != want.last) begin
            $display("%0t: last mismatch: expected %0d, actual %0d",
                     $time, want.last, got.last);
            error_count++;
        end
    endfunction

    // Builds a random word. Most are well-formed: short delays against the
    // running clock and ticks that move it on by a few milliseconds, so the
    // queue fills, hits full and drains in bursts. The rest are huge or
    // negative delays and ticks or requests at an arbitrary time.
    function automatic in_word_t random_word();
        in_word_t    w;
        int unsigned pick;
        pick          = $urandom_range(0, 99);
        w.opcode      = OP_DELAY;
        w.process_tag = TAG_W'($urandom);
        w.delay_ms    = $urandom_range(0, 6);
        w.now         = clock_now;
        if (pick < 7) begin
            w.delay_ms = $urandom;
        end else if (pick < 12) begin
            w.delay_ms = {1'b1, 31'($urandom)};
        end else if (pick < 47) begin
            w.opcode   = OP_TICK;
            w.delay_ms = $urandom;
            clock_now  = clock_now + 64'($urandom_range(0, 3)) * {44'b0, rate_ticks}
                         + 64'($urandom_range(0, 2));
            w.now      = clock_now;
        end else if (pick < 52) begin
            w.opcode = OP_TICK;
            w.now    = {$urandom, $urandom};
        end else if (pick < 55) begin
            w.now = {$urandom, $urandom};
        end
        return w;
    endfunction

    // Offers one word and returns in the time step of the edge that takes
    // it. valid stays high across back-to-back words, so it is only lowered
    // when a gap is drawn.
    task automatic send_word(input in_word_t w);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        words_sent++;
    endtask

    // Holds the sender back until every owed result word has arrived. It
    // always lets one edge pass, so valid is never lowered and raised again
    // within a single time step.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited_words.size() != 0)
            @(posedge aclk);
    endtask

    task automatic settle_queue();
        drain_results();
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // Register write: setup, then access; the register takes the
    // value at the edge that ends the access cycle.
    task automatic write_rate(input logic [RATE_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_TICKS_PER_MS, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        rate_ticks = value;
    endtask

    // Rates for the random phases: a rate of one, a zero rate that pins the
    // wake time to the request time, the largest 20-bit value, one million,
    // a small odd rate and finally the reset value written back explicitly.
    function automatic logic [RATE_W-1:0] phase_rate(int p);
        case (p)
            0:       return RATE_W'(1);
            1:       return '0;
            2:       return '1;
            3:       return RATE_W'(1000000);
            4:       return RATE_W'(7);
            default: return TICKS_PER_MS_RST;
        endcase
    endfunction

    // Result side: takes each word, checks it, then draws a stall for the
    // next one. In burst stretches ready stays high throughout.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold = 0;
        end else if (m_valid && m_ready) begin
            check_result_word(m_data);
            rx_hold = rx_burst ? 0 : $urandom_range(0, 5);
            m_ready <= (rx_hold == 0);
        end else if (rx_hold != 0) begin
            rx_hold = rx_hold - 1;
            m_ready <= (rx_hold == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: any accepted word or register access counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d result words still owed",
                     $time, IDLE_LIMIT, awaited_words.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        dir_row_t row;
        in_word_t w;
        words_sent    = 0;
        tx_burst      = 1'b0;
        rx_burst      = 1'b0;
        rate_ticks    = TICKS_PER_MS_RST;
        clock_now     = '0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, run at the reset rate of 1000 ticks per millisecond.
        // An empty tick, rejects for negative delays at both ends of the
        // range, then eight accepted requests: zero delay, the largest delay,
        // an equal wake time that must go in front, a sum that wraps past the
        // top of the 64-bit clock and a wake time at the very top. A ninth
        // request meets a full queue, and a negative delay on a full queue is
        // still reported as negative. Ticks then release entries in order,
        // the last of them at the top of the clock.
        dir_rows.push_back(mk_row(OP_TICK,  8'hA5, 32'h7FFF_FFFF, 64'd0,   1'b1,
                                  ST_NOTHING_DUE, 8'h00));
        dir_rows.push_back(mk_row(OP_DELAY, 8'h11, 32'hFFFF_FFFF, 64'd0,   1'b1,
                                  ST_NEG_DELAY, 8'h11));
        dir_rows.push_back(mk_row(OP_DELAY, 8'h22, 32'h8000_0000, 64'd5,   1'b1,
                                  ST_NEG_DELAY, 8'h22));
        dir_rows.push_back(mk_row(OP_DELAY, 8'h00, 32'd0,         64'd100, 1'b1,
                                  ST_ACCEPTED, 8'h00));
        dir_rows.push_back(mk_row(OP_DELAY, 8'hFF, 32'h7FFF_FFFF, 64'd0,   1'b1,
                                  ST_ACCEPTED, 8'hFF));
        dir_rows.push_back(mk_row(OP_DELAY, 8'h33, 32'd0,         64'd100, 1'b1,
                                  ST_ACCEPTED, 8'h33));
        dir_rows.push_back(mk_row(OP_DELAY, 8'h44, 32'd1,         '1,      1'b1,
                                  ST_ACCEPTED, 8'h44));
        dir_rows.push_back(mk_row(OP_DELAY, 8'h55, 32'd5,         64'd0,   1'b1,
                                  ST_ACCEPTED, 8'h55));
        dir_rows.push_back(mk_row(OP_DELAY, 8'h66, 32'd2,         64'd0,   1'b1,
                                  ST_ACCEPTED, 8'h66));
        dir_rows.push_back(mk_row(OP_DELAY, 8'h77, 32'd3,         64'd0,   1'b1,
                                  ST_ACCEPTED, 8'h77));
        dir_rows.push_back(mk_row(OP_DELAY, 8'h88, 32'd0,         '1,      1'b1,
                                  ST_ACCEPTED, 8'h88));
        dir_rows.push_back(mk_row(OP_DELAY, 8'h99, 32'd1,         64'd0,   1'b1,
                                  ST_QUEUE_FULL, 8'h99));
        dir_rows.push_back(mk_row(OP_DELAY, 8'hAA, 32'hFFFF_FFFB, 64'd0,   1'b1,
                                  ST_NEG_DELAY, 8'hAA));
        dir_rows.push_back(mk_row(OP_TICK,  8'h00, 32'd0,         64'd99,  1'b1,
                                  ST_NOTHING_DUE, 8'h00));
        dir_rows.push_back(mk_row(OP_TICK,  8'h5C, 32'd9,         64'd100, 1'b0,
                                  ST_ACCEPTED, 8'h00));
        dir_rows.push_back(mk_row(OP_DELAY, 8'h5A, 32'd0,         64'd999, 1'b1,
                                  ST_ACCEPTED, 8'h5A));
        dir_rows.push_back(mk_row(OP_TICK,  8'h01, 32'd0,         64'd999, 1'b0,
                                  ST_ACCEPTED, 8'h00));
        dir_rows.push_back(mk_row(OP_TICK,  8'hFF, 32'hFFFF_FFFF, '1,      1'b0,
                                  ST_ACCEPTED, 8'h00));
        dir_rows.push_back(mk_row(OP_TICK,  8'h7E, 32'h8000_0000, 64'd0,   1'b1,
                                  ST_NOTHING_DUE, 8'h00));

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send_word(row.stim);
            advance_wakeups(row.stim);
            if (row.typed) begin
                awaited_words.push_back(row.want);
            end else begin
                foreach (step_words[j])
                    awaited_words.push_back(step_words[j]);
            end
            // Once the queue is full, stop and let every owed word come back
            // before going on.
            if (i == 11)
                drain_results();
        end
        settle_queue();

        // Random phases, each at its own rate. Every phase starts its clock
        // somewhere new, one in four of them just below the point where it
        // wraps. Idling is redrawn every twenty words, and the first stretch
        // runs with neither side idling.
        for (int p = 0; p < N_PHASES; p++) begin
            write_rate(phase_rate(p));
            case ($urandom_range(0, 3))
                0:       clock_now = {$urandom, $urandom};
                1:       clock_now = '1 - 64'($urandom_range(0, 40)) * {44'b0, rate_ticks};
                default: clock_now = 64'($urandom);
            endcase
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (k % 20 == 0) begin
                    tx_burst = (p == 0 && k == 0) || ($urandom_range(0, 2) == 0);
                    rx_burst = (p == 0 && k == 0) || ($urandom_range(0, 2) == 0);
                end
                w = random_word();
                send_word(w);
                advance_wakeups(w);
                foreach (step_words[j])
                    awaited_words.push_back(step_words[j]);
                if ($urandom_range(0, 29) == 0)
                    drain_results();
            end
            settle_queue();
        end

        $display("Sent %0d request and tick words over %0d tick rates; checked %0d result words",
                 words_sent, N_PHASES, words_checked);
        $display("Saw %0d wake-ups, %0d full rejects, %0d negative delays, %0d empty ticks",
                 woken_seen, full_seen, neg_seen, none_due_seen);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
